### rtl/core/boxcar_moving_average_top_defines.svh
// Assertion macros for the boxcar moving average block
`ifndef BOXCAR_MOVING_AVERAGE_TOP_DEFINES_SVH
`define BOXCAR_MOVING_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define BMA_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define BMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bma_pkg.sv
// Shared constants and divider stage type for the boxcar moving average
package bma_pkg;

    localparam int MAX_WINDOW     = 64;
    localparam int SAMPLE_BITS    = 16;
    localparam int WIN_BITS       = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_BITS      = $clog2(MAX_WINDOW);
    localparam int SUM_BITS       = SAMPLE_BITS + SLOT_BITS;
    localparam int DEFAULT_WINDOW = 8;

    // word: remaining dividend bits at the top, quotient bits shifting in below
    typedef struct packed {
        logic                   valid;
        logic [WIN_BITS-1:0]    rem;
        logic [SAMPLE_BITS-1:0] word;
        logic [WIN_BITS-1:0]    divisor;
    } div_stage_t;

endpackage

### rtl/core/bma_div_cell.sv
// One restoring-division cell: resolves one quotient bit and hands on to the next cell
module bma_div_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  bma_pkg::div_stage_t stage_in,
    output bma_pkg::div_stage_t stage_out
);
    import bma_pkg::*;

    logic [WIN_BITS:0]      trial;
    logic [WIN_BITS:0]      divisor_ext;
    logic                   fits;
    logic [WIN_BITS-1:0]    rem_next;
    logic                   valid_reg;
    logic [WIN_BITS-1:0]    rem_reg;
    logic [SAMPLE_BITS-1:0] word_reg;
    logic [WIN_BITS-1:0]    divisor_reg;

    assign trial       = {stage_in.rem, stage_in.word[SAMPLE_BITS-1]};
    assign divisor_ext = {1'b0, stage_in.divisor};
    assign fits        = (trial >= divisor_ext);
    assign rem_next    = fits ? WIN_BITS'(trial - divisor_ext) : WIN_BITS'(trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg     <= rem_next;
            word_reg    <= {stage_in.word[SAMPLE_BITS-2:0], fits};
            divisor_reg <= stage_in.divisor;
        end
    end

    assign stage_out = {valid_reg, rem_reg, word_reg, divisor_reg};

endmodule

### rtl/core/bma_window.sv
// Sample history, running sum and fill count; issues one division per transaction
module bma_window (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bma_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                            s_first,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bma_pkg::WIN_BITS-1:0]    cfg_window_length,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            item_done,
    output bma_pkg::div_stage_t             launch
);
    import bma_pkg::*;

    logic [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] hist_q_reg;

    logic [WIN_BITS-1:0]    window_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [WIN_BITS-1:0]    fill_reg;
    logic [SLOT_BITS-1:0]   write_slot_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   busy_reg;
    logic                   update_reg;
    logic                   launch_valid_reg;
    logic [WIN_BITS-1:0]    launch_rem_reg;
    logic [SAMPLE_BITS-1:0] launch_word_reg;
    logic [WIN_BITS-1:0]    launch_divisor_reg;

    logic                   s_accept;
    logic                   cfg_accept;
    logic [WIN_BITS-1:0]    win_eff;
    logic [SLOT_BITS-1:0]   slot_sel;
    logic                   full;
    logic [SAMPLE_BITS-1:0] leaving;
    logic [SUM_BITS-1:0]    sum_next;
    logic [WIN_BITS-1:0]    fill_next;
    logic [WIN_BITS-1:0]    slot_inc;
    logic [SLOT_BITS-1:0]   write_slot_next;

    assign cfg_ready  = !busy_reg;
    assign s_ready    = !busy_reg && !cfg_valid;
    assign s_accept   = s_valid && s_ready;
    assign cfg_accept = cfg_valid && cfg_ready;

    always_comb begin
        priority if (window_reg == '0) begin
            win_eff = WIN_BITS'(1);
        end else if (window_reg > WIN_BITS'(MAX_WINDOW)) begin
            win_eff = WIN_BITS'(MAX_WINDOW);
        end else begin
            win_eff = window_reg;
        end
    end

    assign slot_sel = (s_first || ({1'b0, write_slot_reg} >= win_eff)) ? '0 : write_slot_reg;

    assign full      = (fill_reg >= win_eff);
    assign leaving   = full ? hist_q_reg : '0;
    assign sum_next  = sum_reg - SUM_BITS'(leaving) + SUM_BITS'(sample_reg);
    assign fill_next = full ? win_eff : WIN_BITS'(fill_reg + 1'b1);
    assign slot_inc  = WIN_BITS'({1'b0, slot_reg} + 1'b1);
    assign write_slot_next = (slot_inc >= win_eff) ? '0 : slot_inc[SLOT_BITS-1:0];

    // history: read on acceptance, written back in the following cycle
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hist_q_reg <= hist_mem[slot_sel];
        end
        if (update_reg) begin
            hist_mem[slot_reg] <= sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg       <= WIN_BITS'(DEFAULT_WINDOW);
            sum_reg          <= '0;
            fill_reg         <= '0;
            write_slot_reg   <= '0;
            busy_reg         <= 1'b0;
            update_reg       <= 1'b0;
            launch_valid_reg <= 1'b0;
        end else begin
            update_reg       <= s_accept;
            launch_valid_reg <= update_reg;
            if (cfg_accept) begin
                window_reg     <= cfg_window_length;
                sum_reg        <= '0;
                fill_reg       <= '0;
                write_slot_reg <= '0;
            end else if (s_accept) begin
                busy_reg <= 1'b1;
                if (s_first) begin
                    sum_reg  <= '0;
                    fill_reg <= '0;
                end
            end else if (update_reg) begin
                sum_reg        <= sum_next;
                fill_reg       <= fill_next;
                write_slot_reg <= write_slot_next;
            end else if (item_done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_sample;
            slot_reg   <= slot_sel;
        end
        if (update_reg) begin
            launch_rem_reg     <= WIN_BITS'(sum_next >> SAMPLE_BITS);
            launch_word_reg    <= sum_next[SAMPLE_BITS-1:0];
            launch_divisor_reg <= fill_next;
        end
    end

    assign launch = {launch_valid_reg, launch_rem_reg, launch_word_reg, launch_divisor_reg};

endmodule

### rtl/core/boxcar_moving_average_top.sv
// Boxcar moving average: window front end, divider cell chain and output register
//
// Usage:
//   s_ channel: one sample per transaction; s_first restarts the series.
//   m_ channel: one average per input transaction, floor(sum / count),
//   in input order.
//   cfg channel: writes the window length (0 acts as 1, above 64 as 64)
//   and restarts the series. Write only while no transaction is in flight.
// Path: an input passes the history read, the sum update, the 16-cell
//   division chain and the output register; one item at a time is in
//   flight, and the next input waits until the result leaves the chain.
// Reset: window length 8, empty series, no result pending. History
//   content is not cleared; only entries written since a restart are read.
// Stall: the result waits in the output register; the next input is
//   taken meanwhile, and if its result arrives before the first is taken
//   the last cell holds it.
module boxcar_moving_average_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bma_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                            s_first,
    input  logic                            s_valid,
    output logic                            s_ready,
    output logic [bma_pkg::SAMPLE_BITS-1:0] m_average,
    output logic                            m_valid,
    input  logic                            m_ready,
    input  logic [bma_pkg::WIN_BITS-1:0]    cfg_window_length,
    input  logic                            cfg_valid,
    output logic                            cfg_ready
);
    import bma_pkg::*;

    `include "boxcar_moving_average_top_defines.svh"

    div_stage_t               stage [SAMPLE_BITS+1];
    logic [SAMPLE_BITS:0]     chain_valid;
    logic                     advance;
    logic                     item_done;
    logic                     m_valid_reg;
    logic [SAMPLE_BITS-1:0]   m_average_reg;

    assign advance   = !stage[SAMPLE_BITS].valid || !m_valid_reg || m_ready;
    assign item_done = stage[SAMPLE_BITS].valid && advance;

    bma_window u_window (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_sample          (s_sample),
        .s_first           (s_first),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .cfg_window_length (cfg_window_length),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .item_done         (item_done),
        .launch            (stage[0])
    );

    for (genvar i = 0; i < SAMPLE_BITS; i++) begin : g_cell
        bma_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .stage_in  (stage[i]),
            .stage_out (stage[i+1])
        );
    end

    for (genvar i = 0; i <= SAMPLE_BITS; i++) begin : g_valid
        assign chain_valid[i] = stage[i].valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_done) begin
            m_average_reg <= stage[SAMPLE_BITS].word;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

    `BMA_ASSERT_SAME(a_one_in_chain, aclk, aresetn, 1'b1, $onehot0(chain_valid),
        "more than one transaction in the divider chain")
    `BMA_ASSERT_SAME(a_accept_chain_empty, aclk, aresetn, s_valid && s_ready,
        chain_valid == '0, "input taken while a division is in flight")
    `BMA_ASSERT_NEXT(a_stall_holds, aclk, aresetn,
        stage[SAMPLE_BITS].valid && m_valid && !m_ready,
        stage[SAMPLE_BITS].valid && m_valid, "finished quotient lost during a stall")

endmodule

### tb/boxcar_moving_average_top_tb.sv
// Testbench for the boxcar moving average: directed and random sample streams, self-checking
`timescale 1ns / 100ps

module boxcar_moving_average_top_tb;

    import bma_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 560;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic [SAMPLE_BITS-1:0] s_sample = '0;
    logic                   s_first = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] m_average;
    logic                   m_valid;
    logic                   m_ready = 1'b1;
    logic [WIN_BITS-1:0]    cfg_window_length = '0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;

    // predictor state
    logic [WIN_BITS-1:0]    win_len_reg;
    logic [SAMPLE_BITS-1:0] hist_mem [MAX_WINDOW];
    logic [SUM_BITS-1:0]    win_sum;
    logic [WIN_BITS-1:0]    fill_cnt;
    logic [SLOT_BITS-1:0]   wr_slot;

    logic [SAMPLE_BITS-1:0] expected_avg_q [$];
    int                     avg_outstanding = 0;
    int                     errors = 0;
    int                     idle_cycles = 0;

    // sender / receiver behaviour
    bit                     tx_gaps_on = 1'b1;
    bit                     rx_stalls_on = 1'b1;
    int                     hold_len = 0;
    bit                     hold_tog = 1'b0;

    boxcar_moving_average_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_sample          (s_sample),
        .s_first           (s_first),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .m_average         (m_average),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .cfg_window_length (cfg_window_length),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void restart_series();
        win_sum  = '0;
        fill_cnt = '0;
        wr_slot  = '0;
    endfunction

    function automatic int unsigned eff_window(input logic [WIN_BITS-1:0] len);
        if (len == 0)
            return 1;
        if (len > MAX_WINDOW)
            return MAX_WINDOW;
        return 32'(len);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] predict_average(
        input logic [SAMPLE_BITS-1:0] smp,
        input logic                   is_first
    );
        int unsigned         w;
        int unsigned         slot;
        logic [SUM_BITS-1:0] quot;
        w = eff_window(win_len_reg);
        if (is_first)
            restart_series();
        if (wr_slot >= w)
            wr_slot = '0;
        slot = 32'(wr_slot);
        if (fill_cnt >= w) begin
            win_sum  = win_sum - SUM_BITS'(hist_mem[slot]);
            fill_cnt = WIN_BITS'(w);
        end else begin
            fill_cnt = WIN_BITS'(fill_cnt + 1);
        end
        hist_mem[slot] = smp;
        win_sum        = win_sum + SUM_BITS'(smp);
        wr_slot        = (slot + 1 >= w) ? '0 : SLOT_BITS'(slot + 1);
        quot           = win_sum / fill_cnt;
        return quot[SAMPLE_BITS-1:0];
    endfunction

    // mostly short, now and then long
    function automatic int pick_len();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return SAMPLE_BITS'(16'hFFFF - $urandom_range(0, 15));
            1: return SAMPLE_BITS'($urandom_range(0, 15));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic push_sample(input logic [SAMPLE_BITS-1:0] smp, input logic is_first);
        int gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 1))
            gap = pick_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_first  <= is_first;
        do @(posedge aclk); while (!s_ready);
        expected_avg_q = {expected_avg_q, predict_average(smp, is_first)};
        avg_outstanding++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        wait (avg_outstanding == 0);
        @(posedge aclk);
    endtask

    task automatic write_window(input logic [WIN_BITS-1:0] len);
        drain();
        cfg_valid         <= 1'b1;
        cfg_window_length <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len_reg = len;
        restart_series();
    endtask

    task automatic test_default_window();
        logic [SAMPLE_BITS-1:0] vals [10];
        vals = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF,
                 16'h8000, 16'h3039, 16'hFFFF, 16'hFFFF, 16'h0000};
        // no first flag: the first transaction after reset opens the series anyway
        foreach (vals[i])
            push_sample(vals[i], 1'b0);
    endtask

    task automatic test_first_flag();
        push_sample(16'd100, 1'b1);
        push_sample(16'd200, 1'b0);
        push_sample(16'hFFFF, 1'b1);
    endtask

    task automatic test_window_extremes();
        write_window(7'd0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd7, 1'b0);
        write_window(7'd127);
        push_sample(16'hAAAA, 1'b0);
        push_sample(16'h5555, 1'b0);
        write_window(7'd65);
        push_sample(16'hFFFF, 1'b0);
        write_window(7'd1);
        push_sample(16'd9, 1'b0);
        push_sample(16'd3, 1'b0);
        write_window(7'd64);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'hFFFE, 1'b0);
    endtask

    task automatic test_random_series();
        int sent;
        int len;
        logic [WIN_BITS-1:0] w;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w = 7'd1;
                1: w = 7'd2;
                2: w = 7'd64;
                3: w = 7'd0;
                4: w = 7'd127;
                5: w = WIN_BITS'($urandom_range(65, 126));
                default: w = WIN_BITS'($urandom_range(1, 64));
            endcase
            write_window(w);
            len = (eff_window(w) >= 32) ? $urandom_range(70, 130) : $urandom_range(20, 60);
            repeat (len) begin
                push_sample(rand_sample(), $urandom_range(0, 39) == 0);
                sent++;
            end
        end
    endtask

    task automatic test_output_backpressure();
        write_window(7'd4);
        hold_len <= 300;
        hold_tog <= ~hold_tog;
        tx_gaps_on = 1'b0;
        repeat (20)
            push_sample(rand_sample(), 1'b0);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (10)
            push_sample(rand_sample(), 1'b0);
        drain();
        repeat (10)
            push_sample(rand_sample(), 1'b0);
    endtask

    task automatic test_full_rate();
        rx_stalls_on <= 1'b0;
        tx_gaps_on = 1'b0;
        write_window(7'd16);
        repeat (40)
            push_sample(rand_sample(), 1'b0);
        tx_gaps_on = 1'b1;
        rx_stalls_on <= 1'b1;
    endtask

    // receiver: random stalls plus the requested long hold-off
    initial begin
        bit hold_ack;
        int hold_left;
        int stall_left;
        bit rdy;
        hold_ack   = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_tog != hold_ack) begin
                hold_ack  = hold_tog;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 99) < 20) begin
                stall_left = pick_len() - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    always @(posedge aclk) begin
        logic [SAMPLE_BITS-1:0] exp_avg;
        if (aresetn && m_valid && m_ready) begin
            if (expected_avg_q.size() == 0) begin
                $error("average: unexpected transaction, got %0d", m_average);
                errors++;
            end else begin
                exp_avg = expected_avg_q.pop_front();
                avg_outstanding--;
                if (m_average !== exp_avg) begin
                    $error("average: expected %0d, got %0d", exp_avg, m_average);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        win_len_reg = WIN_BITS'(DEFAULT_WINDOW);
        restart_series();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_window();
        test_first_flag();
        test_window_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();
        test_random_series();

        drain();
        repeat (40) @(posedge aclk);
        if (errors == 0 && expected_avg_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
